>>> hw/rtl/sorted_top_n_insert_table_defines.svh
// Assertion macros used by the checker module of the sorted top-N table.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef SORTED_TOP_N_INSERT_TABLE_DEFINES_SVH
`define SORTED_TOP_N_INSERT_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STNIT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stnit check failed");

// The consequent must hold in the cycle after the antecedent.
`define STNIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stnit check failed");

`endif

>>> hw/rtl/stnit_pkg.sv
// Shared constants, codes and controller/datapath bundles of the sorted top-N table.
// Depends on nothing.
package stnit_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int REC_W     = 64;
    localparam int IDX_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 4;
    localparam int COUNT_W   = 5;
    localparam int REQ_W     = 2;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BELOW_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_INDEX = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd5;

    typedef struct packed {
        logic                capture;
        logic                pos_clr;
        logic                pos_inc;
        logic                rd_pos;
        logic                rd_idx;
        logic                rd_prev;
        logic                k_init;
        logic                k_dec;
        logic                wr_k;
        logic                wr_pos;
        logic                count_clr;
        logic                count_inc;
        logic                st_load;
        logic [STATUS_W-1:0] st_code;
        logic                out_load;
    } stnit_cmd_t;

    typedef struct packed {
        logic             pos_lt_count;
        logic             pos_full;
        logic             rd_gt_rec;
        logic             rd_eq_rec;
        logic             k_gt_pos;
        logic             idx_valid;
        logic             out_free;
        logic [REQ_W-1:0] req_type;
    } stnit_stat_t;

endpackage

>>> hw/rtl/sorted_top_n_insert_table.sv
// Sorted top-N record table, top level: controller plus datapath.
// Depends on stnit_pkg, stnit_ctrl and stnit_dpath.
//
// The table keeps up to DEPTH records (32-bit score, 16-bit lines, 16-bit level) in
// descending order in a single-port memory with a registered read. One request is
// worked at a time. An insert scans from rank 0, reading and comparing each record
// that ranks above it, then moves each lower record down one place with a read and
// a write, and writes the new record. A duplicate ends the scan at the equal record,
// and a record below a full table ends it after the last rank. A result that still
// waits on the output holds the controller until the next result can be loaded.
// The input is taken again once the result has been loaded, even while the result
// still waits on the output. No clearing pass follows reset; only records of ranks
// below the held count are ever returned.
module sorted_top_n_insert_table
    import stnit_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // new_score[31:0], new_lines[47:32], new_level[63:48], read_index[67:64], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // position[3:0], entry_score[35:4], entry_lines[51:36], entry_level[67:52],
    // entry_count[72:68], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    stnit_cmd_t  cmd;
    stnit_stat_t stat;

    stnit_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    stnit_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> hw/rtl/stnit_dpath.sv
// Datapath of the sorted top-N table: record memory, search and shift counters,
// entry count and the output register. Depends on stnit_pkg.
module stnit_dpath
    import stnit_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 m_axis_tready,
    output logic                 m_axis_tvalid,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    input  stnit_cmd_t           cmd,
    output stnit_stat_t          stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(DEPTH - 1);

    logic [REC_W-1:0]    mem [DEPTH];
    logic [REC_W-1:0]    rd_data_reg;
    logic [REC_W-1:0]    rec_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       pos_next;
    logic [CW-1:0]       k_reg;
    logic [CW-1:0]       k_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_TDATA_W-1:0] out_tdata_reg;
    logic [M_TUSER_W-1:0] out_tuser_reg;

    logic [REC_W-1:0]    in_rec;
    logic [AW+3:0]       idx_wide;
    logic [AW+3:0]       count_wide;
    logic [CW-1:0]       k_prev;
    logic [CW+3:0]       pos_wide;
    logic [CW+4:0]       cnt_wide;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [REC_W-1:0]    wr_data;
    logic [POS_W-1:0]    out_pos;
    logic [REC_W-1:0]    out_entry;

    // Records are packed score, lines, level from the top bit down, so a plain
    // unsigned compare gives the lexicographic order.
    assign in_rec = {s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tdata[63:48]};

    assign idx_wide   = {{AW{1'b0}}, idx_reg};
    assign count_wide = {{(AW + 4 - CW){1'b0}}, count_reg};
    assign k_prev     = k_reg - CW'(1);
    assign pos_wide   = {4'b0, pos_reg};
    assign cnt_wide   = {5'b0, count_reg};

    assign stat.pos_lt_count = pos_reg < count_reg;
    assign stat.pos_full     = pos_reg >= DEPTH_C;
    assign stat.rd_gt_rec    = rd_data_reg > rec_reg;
    assign stat.rd_eq_rec    = rd_data_reg == rec_reg;
    assign stat.k_gt_pos     = k_reg > pos_reg;
    assign stat.idx_valid    = idx_wide < count_wide;
    assign stat.out_free     = !out_valid_reg || m_axis_tready;
    assign stat.req_type     = s_axis_tuser[REQ_W-1:0];

    always_comb
    begin
        rd_en   = cmd.rd_pos || cmd.rd_idx || cmd.rd_prev;
        rd_addr = pos_reg[AW-1:0];
        if (cmd.rd_idx)
        begin
            rd_addr = idx_wide[AW-1:0];
        end
        else if (cmd.rd_prev)
        begin
            rd_addr = k_prev[AW-1:0];
        end
        wr_en   = cmd.wr_k || cmd.wr_pos;
        wr_addr = cmd.wr_k ? k_reg[AW-1:0] : pos_reg[AW-1:0];
        wr_data = cmd.wr_k ? rd_data_reg : rec_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.pos_clr)
        begin
            pos_next = '0;
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_reg + CW'(1);
        end

        k_next = k_reg;
        if (cmd.k_init)
        begin
            k_next = (count_reg < DEPTH_C) ? count_reg : LAST_C;
        end
        else if (cmd.k_dec)
        begin
            k_next = k_prev;
        end

        count_next = count_reg;
        if (cmd.count_clr)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc && (count_reg != DEPTH_C))
        begin
            count_next = count_reg + CW'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_pos   = (status_reg == ST_INSERTED) ? pos_wide[POS_W-1:0] : '0;
    assign out_entry = (status_reg == ST_READ_OK) ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rec_reg <= in_rec;
            idx_reg <= s_axis_tdata[67:64];
        end
        if (cmd.st_load)
        begin
            status_reg <= cmd.st_code;
        end
        if (cmd.out_load)
        begin
            out_tuser_reg <= status_reg;
            out_tdata_reg <= {7'b0, cnt_wide[COUNT_W-1:0], out_entry[15:0],
                              out_entry[31:16], out_entry[63:32], out_pos};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

endmodule

>>> hw/rtl/stnit_ctrl.sv
// Controller of the sorted top-N table: sequences search, shift, place, read
// and clear over the datapath. Depends on stnit_pkg.
module stnit_ctrl
    import stnit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  stnit_stat_t stat,
    output stnit_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SRCH_RD  = 3'd1;
    localparam logic [2:0] S_SRCH_CMP = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_PLACE    = 3'd5;
    localparam logic [2:0] S_READ     = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    unique case (stat.req_type)
                        REQ_INSERT:
                        begin
                            cmd.pos_clr = 1'b1;
                            state_next  = S_SRCH_RD;
                        end
                        REQ_READ:
                        begin
                            state_next = S_READ;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.count_clr = 1'b1;
                            cmd.st_load   = 1'b1;
                            cmd.st_code   = ST_CLEARED;
                            state_next    = S_DONE;
                        end
                        // An unknown request is taken and dropped without a result.
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (stat.pos_lt_count)
                begin
                    cmd.rd_pos = 1'b1;
                    state_next = S_SRCH_CMP;
                end
                else if (stat.pos_full)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_BELOW_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.k_init = 1'b1;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.rd_gt_rec)
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_SRCH_RD;
                end
                else if (stat.rd_eq_rec)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_DUPLICATE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.k_init = 1'b1;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.k_gt_pos)
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_k   = 1'b1;
                cmd.k_dec  = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_PLACE:
            begin
                cmd.wr_pos    = 1'b1;
                cmd.count_inc = 1'b1;
                cmd.st_load   = 1'b1;
                cmd.st_code   = ST_INSERTED;
                state_next    = S_DONE;
            end
            S_READ:
            begin
                cmd.rd_idx  = 1'b1;
                cmd.st_load = 1'b1;
                cmd.st_code = stat.idx_valid ? ST_READ_OK : ST_EMPTY_INDEX;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/stnit_checker.sv
// Port-level checks of the sorted top-N table, bound to the top level.
// Depends on stnit_pkg and sorted_top_n_insert_table_defines.svh.
`include "sorted_top_n_insert_table_defines.svh"

module stnit_checker
    import stnit_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // A stalled result holds still.
    `STNIT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Entry fields carry data only for a successful read.
    `STNIT_ASSERT_NOW(a_entry_zero, m_axis_tvalid && (m_axis_tuser != ST_READ_OK),
        m_axis_tdata[67:4] == 64'd0)

    // Position is reported only for an insert.
    `STNIT_ASSERT_NOW(a_pos_zero, m_axis_tvalid && (m_axis_tuser != ST_INSERTED),
        m_axis_tdata[3:0] == 4'd0)

    // A clear leaves the table empty.
    `STNIT_ASSERT_NOW(a_clear_empty, m_axis_tvalid && (m_axis_tuser == ST_CLEARED),
        m_axis_tdata[72:68] == 5'd0)

endmodule

bind sorted_top_n_insert_table stnit_checker u_stnit_checker (.*);
